// ===== hdl/pcd_pkg.sv =====
// shared types and constants for the polygon containment block
package pcd_pkg;

    localparam int DIST_BITS = 31;
    localparam int DIST_CW   = 5;

    localparam logic [4:0]  VERTEX_COUNT_RESET = 5'd4;
    localparam logic [30:0] EDGE_BAND_RESET    = 31'd536871;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_BAND    = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_QUERY = 1'b0;
    localparam logic STATUS_LOAD  = 1'b1;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic                 degen;
        logic                 cross_pos;
        logic                 cross_neg;
        logic [DIST_BITS-1:0] line_dist;
    } edge_res_t;

endpackage

// ===== hdl/pcd_if.sv =====
// item and result channel interfaces
interface pcd_item_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [3:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, opcode, vertex_index, coord_x, coord_y, input ready);
    modport sink (input valid, opcode, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pcd_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        inside_res;
    logic        on_edge;
    logic [30:0] min_dist;

    modport source (output valid, status, inside_res, on_edge, min_dist, input ready);
    modport sink (input valid, status, inside_res, on_edge, min_dist, output ready);
endinterface

// ===== hdl/pcd_vmem.sv =====
// vertex memory, one write port and one registered read port
module pcd_vmem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/pcd_edge.sv =====
// per-edge unit: cross product, squared length and bit-serial line distance
module pcd_edge
    import pcd_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] sx,
    input  logic signed [COORD_BITS-1:0] sy,
    input  logic signed [COORD_BITS-1:0] tx,
    input  logic signed [COORD_BITS-1:0] ty,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output edge_res_t                    res
);

    localparam int D  = COORD_BITS + 1;
    localparam int MW = D + 1;
    localparam int PW = 2 * MW;
    localparam int W  = ((4 * D > 2 * D + 2 * DIST_BITS) ? 4 * D : 2 * D + 2 * DIST_BITS) + 2;

    typedef enum logic [3:0] {
        E_IDLE, E_M1, E_M2, E_M3, E_M4, E_CR, E_C1, E_C2, E_C3, E_C4, E_SQ
    } estate_t;

    estate_t              state_reg;
    logic signed [D-1:0]  dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, prod_reg;
    logic [2*D-1:0]       len_reg, cmag_reg;
    logic [W-1:0]         r_reg, a_reg, b_reg;
    logic [DIST_BITS-1:0] q_reg;
    logic [DIST_CW-1:0]   cnt_reg;
    logic                 done_reg, degen_reg, cpos_reg, cneg_reg;

    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] cdiff;
    logic [W-1:0]         prod_w, trial;

    always_comb
    begin
        unique case (state_reg)
            E_M1:    begin ma = MW'(dx_reg); mb = MW'(wy_reg); end
            E_M2:    begin ma = MW'(dy_reg); mb = MW'(wx_reg); end
            E_M3:    begin ma = MW'(dx_reg); mb = MW'(dx_reg); end
            E_M4:    begin ma = MW'(dy_reg); mb = MW'(dy_reg); end
            E_C1:    begin ma = {1'b0, cmag_reg[D-1:0]};   mb = {1'b0, cmag_reg[D-1:0]}; end
            E_C2:    begin ma = {1'b0, cmag_reg[2*D-1:D]}; mb = {1'b0, cmag_reg[D-1:0]}; end
            E_C3:    begin ma = {1'b0, cmag_reg[2*D-1:D]}; mb = {1'b0, cmag_reg[2*D-1:D]}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign cdiff  = p1_reg - p2_reg;
    assign prod_w = W'($unsigned(prod_reg));
    assign trial  = a_reg + b_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg    <= D'(sx) - D'(tx);
                        dy_reg    <= D'(sy) - D'(ty);
                        wx_reg    <= D'(px) - D'(tx);
                        wy_reg    <= D'(py) - D'(ty);
                        degen_reg <= (sx == tx) && (sy == ty);
                        state_reg <= E_M1;
                    end
                end
                E_M1: state_reg <= E_M2;
                E_M2:
                begin
                    p1_reg    <= prod_reg;
                    state_reg <= E_M3;
                end
                E_M3:
                begin
                    p2_reg    <= prod_reg;
                    state_reg <= E_M4;
                end
                E_M4:
                begin
                    len_reg   <= prod_reg[2*D-1:0];
                    state_reg <= E_CR;
                end
                E_CR:
                begin
                    len_reg   <= len_reg + prod_reg[2*D-1:0];
                    cpos_reg  <= cdiff > 0;
                    cneg_reg  <= cdiff < 0;
                    cmag_reg  <= (cdiff < 0) ? (2*D)'(-cdiff) : (2*D)'(cdiff);
                    state_reg <= E_C1;
                end
                E_C1: state_reg <= E_C2;
                E_C2:
                begin
                    r_reg     <= prod_w;
                    state_reg <= E_C3;
                end
                E_C3:
                begin
                    r_reg     <= r_reg + (prod_w << (D + 1));
                    state_reg <= E_C4;
                end
                E_C4:
                begin
                    // root search: largest q with q*q*len <= cross*cross
                    r_reg     <= r_reg + (prod_w << (2 * D));
                    a_reg     <= '0;
                    b_reg     <= W'(len_reg) << (2 * (DIST_BITS - 1));
                    q_reg     <= '0;
                    cnt_reg   <= DIST_CW'(DIST_BITS - 1);
                    state_reg <= E_SQ;
                end
                E_SQ:
                begin
                    if (trial <= r_reg)
                    begin
                        r_reg <= r_reg - trial;
                        q_reg <= q_reg | (DIST_BITS'(1) << cnt_reg);
                        a_reg <= (a_reg >> 1) + b_reg;
                    end
                    else
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    b_reg <= b_reg >> 2;
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign res.busy      = state_reg != E_IDLE;
    assign res.done      = done_reg;
    assign res.degen     = degen_reg;
    assign res.cross_pos = cpos_reg;
    assign res.cross_neg = cneg_reg;
    assign res.line_dist = q_reg;

endmodule

// ===== hdl/polygon_containment_and_edge_distance.sv =====
// top level: polygon store, query sequencer and result register
//
// items carries vertex loads and query points; results carries one transfer per item.
// a load writes one vertex slot and is acknowledged with status 1;
// slots at or beyond the vertex capacity are dropped but still acknowledged.
// a query walks the edges of the first vertex_count slots (clamped to 3..capacity),
// reading one vertex per edge from the vertex memory.
// for each edge the vertex is read from memory (S_RDS, S_GETS) and handed to the edge
// unit, where a shared multiplier does seven products in turn, then a 31-step square
// root search finds the line distance.
// one item is in work at a time, and a load passes through S_OUT before the next item
// is accepted.
// configuration writes take effect on the next item and must happen while idle.
// reset sets vertex_count to 4 and edge_band to 0.002 m; vertex slots hold no defined
// value until loaded, and no query may touch an unloaded slot.
// a finished result sits in the output register until the receiver takes it; a new item
// is accepted meanwhile, and its result waits until the output register is free.
module polygon_containment_and_edge_distance
    import pcd_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [30:0]          cfg_wdata,
    pcd_item_if.sink             items,
    pcd_result_if.source         results
);

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int WNW = $clog2(MAX_VERTICES + 1) + 2;
    localparam int CB  = COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_RDT, S_CAPT, S_RDS, S_GETS, S_WAIT, S_OUT
    } state_t;

    state_t                state_reg;
    logic [4:0]            vcount_reg;
    logic [30:0]           band_reg;
    logic [IW-1:0]         idx_reg, last_idx;
    logic signed [CB-1:0]  px_reg, py_reg, tx_reg, ty_reg, sx_reg, sy_reg;
    logic signed [WNW-1:0] wn_reg;
    logic                  hit_reg, status_reg;
    logic [DIST_BITS-1:0]  dmin_reg;
    logic                  out_valid_reg, out_status_reg, out_inside_reg, out_edge_reg;
    logic [30:0]           out_dist_reg;

    logic                  accept, mem_we, mem_re, edge_start;
    logic [IW-1:0]         mem_raddr;
    logic [2*CB-1:0]       mem_rdata;
    logic signed [CB-1:0]  rd_x, rd_y, span_lo, span_hi;
    logic                  in_band, up_cross, down_cross;
    edge_res_t             er;

    assign accept     = items.valid && items.ready;
    assign items.ready = state_reg == S_IDLE;
    assign mem_we     = accept && (items.opcode == OP_LOAD)
                        && (int'(items.vertex_index) < MAX_VERTICES);
    assign mem_re     = (state_reg == S_RDT) || (state_reg == S_RDS);
    assign mem_raddr  = (state_reg == S_RDT) ? last_idx : idx_reg;
    assign rd_x       = mem_rdata[CB-1:0];
    assign rd_y       = mem_rdata[2*CB-1:CB];
    assign edge_start = state_reg == S_GETS;

    always_comb
    begin
        if (vcount_reg < 5'd3)
        begin
            last_idx = IW'(2);
        end
        else if (int'(vcount_reg) > MAX_VERTICES)
        begin
            last_idx = IW'(MAX_VERTICES - 1);
        end
        else
        begin
            last_idx = IW'(vcount_reg - 5'd1);
        end
    end

    pcd_vmem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CB)
    ) u_vmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IW'(items.vertex_index)),
        .wdata ({items.coord_y, items.coord_x}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pcd_edge #(
        .COORD_BITS (CB)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (edge_start),
        .sx    (rd_x),
        .sy    (rd_y),
        .tx    (tx_reg),
        .ty    (ty_reg),
        .px    (px_reg),
        .py    (py_reg),
        .res   (er)
    );

    assign span_lo    = (sx_reg < tx_reg) ? sx_reg : tx_reg;
    assign span_hi    = (sx_reg < tx_reg) ? tx_reg : sx_reg;
    assign in_band    = (er.line_dist < band_reg) && (span_lo <= px_reg) && (px_reg <= span_hi);
    // half-open crossing rule on the ray toward +x
    assign up_cross   = (ty_reg <= py_reg) && (sy_reg > py_reg) && er.cross_pos;
    assign down_cross = (ty_reg > py_reg) && (sy_reg <= py_reg) && er.cross_neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VERTEX_COUNT_RESET;
            band_reg      <= EDGE_BAND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT: vcount_reg <= cfg_wdata[4:0];
                    REG_EDGE_BAND:    band_reg   <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (out_valid_reg && results.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        px_reg   <= items.coord_x;
                        py_reg   <= items.coord_y;
                        wn_reg   <= '0;
                        hit_reg  <= 1'b0;
                        dmin_reg <= '1;
                        idx_reg  <= '0;
                        if (items.opcode == OP_LOAD)
                        begin
                            status_reg <= STATUS_LOAD;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= STATUS_QUERY;
                            state_reg  <= S_RDT;
                        end
                    end
                end
                S_RDT: state_reg <= S_CAPT;
                S_CAPT:
                begin
                    tx_reg    <= rd_x;
                    ty_reg    <= rd_y;
                    state_reg <= S_RDS;
                end
                S_RDS: state_reg <= S_GETS;
                S_GETS:
                begin
                    sx_reg    <= rd_x;
                    sy_reg    <= rd_y;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (er.done)
                    begin
                        if (!er.degen)
                        begin
                            if (er.line_dist < dmin_reg)
                            begin
                                dmin_reg <= er.line_dist;
                            end
                            if (in_band)
                            begin
                                hit_reg <= 1'b1;
                            end
                            if (up_cross)
                            begin
                                wn_reg <= wn_reg + WNW'(1);
                            end
                            else if (down_cross)
                            begin
                                wn_reg <= wn_reg - WNW'(1);
                            end
                        end
                        tx_reg <= sx_reg;
                        ty_reg <= sy_reg;
                        if (idx_reg == last_idx)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RDS;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        if (status_reg == STATUS_LOAD)
                        begin
                            out_inside_reg <= 1'b0;
                            out_edge_reg   <= 1'b0;
                            out_dist_reg   <= '0;
                        end
                        else
                        begin
                            out_inside_reg <= hit_reg || (wn_reg == WNW'(1));
                            out_edge_reg   <= hit_reg;
                            out_dist_reg   <= dmin_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.status     = out_status_reg;
    assign results.inside_res = out_inside_reg;
    assign results.on_edge    = out_edge_reg;
    assign results.min_dist   = out_dist_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        edge_start |-> !er.busy)
        else $error("edge unit started while busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        er.done |-> state_reg == S_WAIT)
        else $error("edge result arrived outside the edge walk");

    a_load_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == STATUS_LOAD)
        |-> (!results.inside_res && !results.on_edge && results.min_dist == '0))
        else $error("load acknowledge carries query fields");

    a_edge_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.on_edge) |-> results.inside_res)
        else $error("on_edge without inside");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> idx_reg <= last_idx)
        else $error("edge index beyond vertex count");

endmodule
